>>> design/vfrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfrt_pkg
// Shared types and constants for the flood replication table.
// ----------------------------------------------------------------------------
package vfrt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [31:0] VNI_MAX = 32'h00FF_FFFF;

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_SET_PORT = 3'd1;
    localparam logic [2:0] OP_DELETE   = 3'd2;
    localparam logic [2:0] OP_DISTRIB  = 3'd3;
    localparam logic [2:0] OP_DUMP     = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_VNI   = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_STATUS,
        S_EMIT,
        S_FLUSH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture the input transaction
        logic scan_clr;   // restart the slot sweep
        logic scan_step;  // read next slot
        logic commit;     // apply add/set/delete at its slot
        logic send_stat;  // load the status result into the output register
        logic send_copy;  // load the pending copy/dump result into the output register
        logic last;       // mark the loaded result as the final one
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic       scan_done;  // every slot has been read
        logic       rd_valid;   // a read slot is presented this cycle
        logic       rd_hit;     // that slot produces a result
        logic       out_busy;   // output register still holds a result
        logic       have_pend;  // a result is waiting for its last flag
        logic [2:0] op;
    } stat_t;

endpackage
`default_nettype wire

>>> design/vfrt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfrt_ctrl
// Sequencer: sweeps the table once per transaction and issues its results.
// ----------------------------------------------------------------------------
module vfrt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_fire,
    output logic                 in_ready,
    input  wire vfrt_pkg::stat_t st,
    output vfrt_pkg::cmd_t       cmd
);

    vfrt_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= vfrt_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vfrt_pkg::S_IDLE:
                if (in_fire)
                    state_next = vfrt_pkg::S_SCAN;
            vfrt_pkg::S_SCAN:
                if (st.scan_done && !st.rd_valid)
                begin
                    if (st.op == vfrt_pkg::OP_ADD || st.op == vfrt_pkg::OP_SET_PORT
                        || st.op == vfrt_pkg::OP_DELETE)
                        state_next = vfrt_pkg::S_WRITE;
                    else
                        state_next = vfrt_pkg::S_IDLE;
                end
                else if (st.op == vfrt_pkg::OP_DISTRIB || st.op == vfrt_pkg::OP_DUMP)
                    state_next = vfrt_pkg::S_EMIT;
            vfrt_pkg::S_EMIT:
                if (st.scan_done && !st.rd_valid)
                    state_next = vfrt_pkg::S_FLUSH;
            vfrt_pkg::S_FLUSH:
                if (!st.out_busy)
                    state_next = vfrt_pkg::S_IDLE;
            vfrt_pkg::S_WRITE:
                state_next = vfrt_pkg::S_STATUS;
            vfrt_pkg::S_STATUS:
                if (!st.out_busy)
                    state_next = vfrt_pkg::S_IDLE;
            default:
                state_next = vfrt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            vfrt_pkg::S_IDLE:
            begin
                in_ready = !st.out_busy;
                cmd.load = in_fire;
                cmd.scan_clr = in_fire;
            end
            vfrt_pkg::S_SCAN:
                cmd.scan_step = 1'b1;
            vfrt_pkg::S_EMIT:
            begin
                // a hit waits until the previous pending result can move out
                cmd.scan_step = !(st.rd_valid && st.rd_hit && st.have_pend && st.out_busy);
                cmd.send_copy = 1'b0;
            end
            vfrt_pkg::S_FLUSH:
            begin
                cmd.send_copy = st.have_pend && !st.out_busy;
                cmd.last = 1'b1;
            end
            vfrt_pkg::S_WRITE:
                cmd.commit = 1'b1;
            vfrt_pkg::S_STATUS:
            begin
                cmd.send_stat = !st.out_busy;
                cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == vfrt_pkg::S_IDLE)
        else $error("ready outside idle");
    a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !cmd.commit)
        else $error("double commit");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == vfrt_pkg::S_SCAN)
        else $error("load without scan");

endmodule
`default_nettype wire

>>> design/vfrt_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfrt_dpath
// Endpoint table memory, slot scanner, counter update and output register.
// ----------------------------------------------------------------------------
module vfrt_dpath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire vfrt_pkg::cmd_t  cmd,
    output vfrt_pkg::stat_t      st,
    input  wire logic [2:0]      in_op,
    input  wire logic [31:0]     in_vni,
    input  wire logic [31:0]     in_eip,
    input  wire logic [15:0]     in_eport,
    input  wire logic [31:0]     in_sip,
    input  wire logic [15:0]     in_pport,
    input  wire logic [15:0]     in_plen,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [2:0]           out_status,
    output logic [23:0]          out_vni,
    output logic [31:0]          out_ip,
    output logic [15:0]          out_port,
    output logic [63:0]          out_pk,
    output logic [63:0]          out_oc,
    output logic                 out_last
);

    localparam int N = vfrt_pkg::TABLE_ENTRIES;
    localparam int IW = vfrt_pkg::IDX_W;
    localparam int CW = vfrt_pkg::CNT_W;

    // entry store: vni, ip, port (written on add / set port)
    logic [71:0]  key_mem [N];
    logic [127:0] cnt_mem [N];
    logic [N-1:0] valid_reg;

    logic [2:0]  op_reg;
    logic [31:0] vni_reg, eip_reg, sip_reg;
    logic [15:0] eport_reg, pport_reg, plen_reg;

    logic [CW-1:0] rd_cnt_reg;
    logic          rd_v_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [71:0]   rd_key_reg;
    logic [127:0]  rd_cnt_data_reg;

    logic          hit_found_reg, free_found_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;

    // pending result, held until the next hit or end of scan sets last
    logic          pend_reg;
    logic [23:0]   pend_vni_reg;
    logic [31:0]   pend_ip_reg;
    logic [15:0]   pend_port_reg;
    logic [127:0]  pend_cnt_reg;

    logic          outv_reg;
    logic [2:0]    ostat_reg;
    logic [23:0]   ovni_reg;
    logic [31:0]   oip_reg;
    logic [15:0]   oport_reg;
    logic [63:0]   opk_reg, ooc_reg;
    logic          olast_reg;

    logic vni_ok, is_dist, is_dump, rd_valid_slot, rd_match, rd_hit, step_ok, push;
    logic out_free;

    assign vni_ok  = (vni_reg <= vfrt_pkg::VNI_MAX);
    assign is_dist = (op_reg == vfrt_pkg::OP_DISTRIB);
    assign is_dump = (op_reg == vfrt_pkg::OP_DUMP);
    assign rd_valid_slot = valid_reg[rd_idx_reg];
    assign rd_match = rd_valid_slot && vni_ok && (rd_key_reg[71:48] == vni_reg[23:0])
                      && (rd_key_reg[47:16] == eip_reg);
    assign rd_hit = rd_valid_slot && (is_dump || (is_dist && vni_ok
                    && rd_key_reg[71:48] == vni_reg[23:0] && rd_key_reg[47:16] != sip_reg));
    assign out_free = !outv_reg || out_ready;
    // a hit with a result pending pushes the pending one to the output
    assign step_ok = cmd.scan_step;
    assign push = rd_v_reg && rd_hit && pend_reg && step_ok;

    assign st.scan_done = (rd_cnt_reg == CW'(N));
    assign st.rd_valid  = rd_v_reg;
    assign st.rd_hit    = rd_hit;
    assign st.out_busy  = !out_free;
    assign st.have_pend = pend_reg;
    assign st.op        = op_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_op; vni_reg <= in_vni; eip_reg <= in_eip;
            eport_reg <= in_eport; sip_reg <= in_sip;
            pport_reg <= in_pport; plen_reg <= in_plen;
        end
    end

    // read port, counter write port and key write port
    always_ff @(posedge clk)
    begin
        if (step_ok && !st.scan_done)
        begin
            rd_key_reg <= key_mem[rd_cnt_reg[IW-1:0]];
            rd_cnt_data_reg <= cnt_mem[rd_cnt_reg[IW-1:0]];
            rd_idx_reg <= rd_cnt_reg[IW-1:0];
        end
        if (step_ok && rd_v_reg && rd_hit && is_dist)
            cnt_mem[rd_idx_reg] <= {rd_cnt_data_reg[127:64] + 64'd1,
                                    rd_cnt_data_reg[63:0] + {48'd0, plen_reg}};
        else if (cmd.commit && op_reg == vfrt_pkg::OP_ADD && vni_ok
                 && !hit_found_reg && free_found_reg)
            cnt_mem[free_idx_reg] <= '0;
        // a matched entry already holds this vni and ip
        if (cmd.commit && vni_ok)
        begin
            if (op_reg == vfrt_pkg::OP_ADD && !hit_found_reg && free_found_reg)
                key_mem[free_idx_reg] <= {vni_reg[23:0], eip_reg, eport_reg};
            else if (op_reg == vfrt_pkg::OP_SET_PORT && hit_found_reg)
                key_mem[hit_idx_reg] <= {vni_reg[23:0], eip_reg, eport_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0; rd_cnt_reg <= '0; rd_v_reg <= 1'b0;
            hit_found_reg <= 1'b0; free_found_reg <= 1'b0; pend_reg <= 1'b0;
            hit_idx_reg <= '0; free_idx_reg <= '0;
            pend_vni_reg <= '0; pend_ip_reg <= '0; pend_port_reg <= '0;
            pend_cnt_reg <= '0;
            outv_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_clr)
            begin
                rd_cnt_reg <= '0; rd_v_reg <= 1'b0;
                hit_found_reg <= 1'b0; free_found_reg <= 1'b0; pend_reg <= 1'b0;
            end
            else if (step_ok)
            begin
                rd_v_reg <= !st.scan_done;
                if (!st.scan_done)
                    rd_cnt_reg <= rd_cnt_reg + CW'(1);
                if (rd_v_reg)
                begin
                    if (rd_match && !hit_found_reg)
                    begin
                        hit_found_reg <= 1'b1; hit_idx_reg <= rd_idx_reg;
                    end
                    if (!rd_valid_slot && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1; free_idx_reg <= rd_idx_reg;
                    end
                    if (rd_hit)
                    begin
                        pend_reg <= 1'b1;
                        pend_vni_reg <= rd_key_reg[71:48];
                        pend_ip_reg <= rd_key_reg[47:16];
                        pend_port_reg <= (is_dist && rd_key_reg[15:0] == 16'd0)
                                         ? pport_reg : rd_key_reg[15:0];
                        pend_cnt_reg <= is_dump ? rd_cnt_data_reg : 128'd0;
                    end
                end
            end
            if (cmd.send_copy)
                pend_reg <= 1'b0;
            if (cmd.commit && vni_ok)
            begin
                if (op_reg == vfrt_pkg::OP_ADD && !hit_found_reg && free_found_reg)
                    valid_reg[free_idx_reg] <= 1'b1;
                else if (op_reg == vfrt_pkg::OP_DELETE && hit_found_reg)
                    valid_reg[hit_idx_reg] <= 1'b0;
            end
            if (push || cmd.send_copy || cmd.send_stat)
                outv_reg <= 1'b1;
            else if (out_ready)
                outv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push || cmd.send_copy)
        begin
            ostat_reg <= vfrt_pkg::ST_OK;
            ovni_reg <= pend_vni_reg; oip_reg <= pend_ip_reg; oport_reg <= pend_port_reg;
            opk_reg <= pend_cnt_reg[127:64]; ooc_reg <= pend_cnt_reg[63:0];
            olast_reg <= cmd.last;
        end
        else if (cmd.send_stat)
        begin
            if (!vni_ok)
                ostat_reg <= vfrt_pkg::ST_BAD_VNI;
            else if (op_reg == vfrt_pkg::OP_ADD)
                ostat_reg <= hit_found_reg ? vfrt_pkg::ST_DUP
                           : (free_found_reg ? vfrt_pkg::ST_OK : vfrt_pkg::ST_FULL);
            else
                ostat_reg <= hit_found_reg ? vfrt_pkg::ST_OK : vfrt_pkg::ST_NOT_FOUND;
            ovni_reg <= '0; oip_reg <= '0; oport_reg <= '0;
            opk_reg <= '0; ooc_reg <= '0; olast_reg <= 1'b1;
        end
    end

    assign out_valid = outv_reg;
    assign out_status = ostat_reg;
    assign out_vni = ovni_reg;
    assign out_ip = oip_reg;
    assign out_port = oport_reg;
    assign out_pk = opk_reg;
    assign out_oc = ooc_reg;
    assign out_last = olast_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (outv_reg && !out_ready) |-> !(push || cmd.send_copy || cmd.send_stat))
        else $error("output overwritten");
    a_push_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.send_copy |-> pend_reg)
        else $error("send without pending result");
    a_commit_scanned: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> st.scan_done && !rd_v_reg)
        else $error("commit before scan end");

endmodule
`default_nettype wire

>>> design/vxlan_flood_replication_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vxlan_flood_replication_table
// Head-end replication table: add/set/delete endpoints, flood copies, dump.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// s_axis   | in  | op, vni, endpoint ip/port, source ip, packet port, length
// m_axis   | out | status, vni, ip, port, counters; tlast ends a transaction
//
// Each transaction sweeps the endpoint memory one slot per cycle over its
// single read port, unless a flood or dump copy is held by a stalled m_axis.
// Add, set port and delete write the table in S_WRITE and then report in S_STATUS.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stalled m_axis can hold a flood or dump sweep; s_axis is taken only between transactions.
// ----------------------------------------------------------------------------
module vxlan_flood_replication_table (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [2:0] operation, [34:3] vni, [66:35] endpoint_ip, [82:67] endpoint_port,
    // [114:83] source_ip, [130:115] packet_dest_port, [146:131] packet_length
    input  wire logic [151:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [2:0] status, [26:3] out_vni, [58:27] dest_ip, [74:59] dest_port,
    // [138:75] packet_count, [202:139] octet_count
    output logic [207:0]      m_axis_tdata,
    output logic              m_axis_tlast
);

    vfrt_pkg::cmd_t  cmd;
    vfrt_pkg::stat_t st;
    logic in_fire;
    logic [2:0] ostat;
    logic [23:0] ovni;
    logic [31:0] oip;
    logic [15:0] oport;
    logic [63:0] opk, ooc;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    vfrt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_ready(s_axis_tready),
        .st(st), .cmd(cmd)
    );

    vfrt_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .in_op(s_axis_tdata[2:0]), .in_vni(s_axis_tdata[34:3]),
        .in_eip(s_axis_tdata[66:35]), .in_eport(s_axis_tdata[82:67]),
        .in_sip(s_axis_tdata[114:83]), .in_pport(s_axis_tdata[130:115]),
        .in_plen(s_axis_tdata[146:131]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_status(ostat), .out_vni(ovni), .out_ip(oip), .out_port(oport),
        .out_pk(opk), .out_oc(ooc), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, ooc, opk, oport, oip, ovni, ostat};

endmodule
`default_nettype wire

>>> verif/vxlan_flood_replication_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vxlan_flood_replication_table_test
// Drives table operations and packet floods into the replication table and
// checks every status, copy and dump transaction against a local table copy.
// ----------------------------------------------------------------------------
module vxlan_flood_replication_table_test;

    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] plen;
        logic [15:0] pport;
        logic [31:0] sip;
        logic [15:0] eport;
        logic [31:0] eip;
        logic [31:0] vni;
        logic [2:0]  op;
    } req_t;

    typedef struct packed {
        logic        last;
        logic [63:0] octets;
        logic [63:0] packets;
        logic [15:0] port;
        logic [31:0] ip;
        logic [23:0] vni;
        logic [2:0]  status;
    } rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [151:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [207:0] m_axis_tdata;
    logic m_axis_tlast;

    vxlan_flood_replication_table u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow endpoint table
    logic        tbl_valid [vfrt_pkg::TABLE_ENTRIES];
    logic [23:0] tbl_vni [vfrt_pkg::TABLE_ENTRIES];
    logic [31:0] tbl_ip [vfrt_pkg::TABLE_ENTRIES];
    logic [15:0] tbl_port [vfrt_pkg::TABLE_ENTRIES];
    logic [63:0] tbl_pkts [vfrt_pkg::TABLE_ENTRIES];
    logic [63:0] tbl_octs [vfrt_pkg::TABLE_ENTRIES];

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   errors = 0;
    bit   stim_done = 0;
    bit   hold_sender = 0;
    bit   long_stall = 0;

    function automatic int lookup_endpoint(logic [31:0] vni, logic [31:0] ip);
        for (int i = 0; i < vfrt_pkg::TABLE_ENTRIES; i++)
            if (tbl_valid[i] && tbl_vni[i] == vni && tbl_ip[i] == ip)
                return i;
        return -1;
    endfunction

    task automatic predict_table_op(req_t r);
        rsp_t rs;
        int   hit;
        int   slot;
        int   n;
        n = 0;
        rs = '0;
        if (r.op <= vfrt_pkg::OP_DELETE) begin
            rs.status = vfrt_pkg::ST_OK;
            if (r.vni > vfrt_pkg::VNI_MAX)
                rs.status = vfrt_pkg::ST_BAD_VNI;
            else begin
                hit = lookup_endpoint(r.vni, r.eip);
                if (r.op == vfrt_pkg::OP_ADD) begin
                    if (hit >= 0)
                        rs.status = vfrt_pkg::ST_DUP;
                    else begin
                        slot = -1;
                        for (int i = 0; i < vfrt_pkg::TABLE_ENTRIES; i++)
                            if (!tbl_valid[i] && slot < 0)
                                slot = i;
                        if (slot < 0)
                            rs.status = vfrt_pkg::ST_FULL;
                        else begin
                            tbl_valid[slot] = 1'b1;
                            tbl_vni[slot] = r.vni[23:0];
                            tbl_ip[slot] = r.eip;
                            tbl_port[slot] = r.eport;
                            tbl_pkts[slot] = '0;
                            tbl_octs[slot] = '0;
                        end
                    end
                end else if (hit < 0)
                    rs.status = vfrt_pkg::ST_NOT_FOUND;
                else if (r.op == vfrt_pkg::OP_SET_PORT)
                    tbl_port[hit] = r.eport;
                else
                    tbl_valid[hit] = 1'b0;
            end
            rs.last = 1'b1;
            expected_rsps.push_back(rs);
        end else if (r.op == vfrt_pkg::OP_DISTRIB || r.op == vfrt_pkg::OP_DUMP) begin
            for (int i = 0; i < vfrt_pkg::TABLE_ENTRIES; i++) begin
                if (!tbl_valid[i])
                    continue;
                rs = '0;
                rs.vni = tbl_vni[i];
                rs.ip = tbl_ip[i];
                if (r.op == vfrt_pkg::OP_DUMP) begin
                    rs.port = tbl_port[i];
                    rs.packets = tbl_pkts[i];
                    rs.octets = tbl_octs[i];
                end else begin
                    if ({8'd0, tbl_vni[i]} != r.vni || tbl_ip[i] == r.sip)
                        continue;
                    rs.port = (tbl_port[i] != 16'd0) ? tbl_port[i] : r.pport;
                    tbl_pkts[i] = tbl_pkts[i] + 64'd1;
                    tbl_octs[i] = tbl_octs[i] + {48'd0, r.plen};
                end
                expected_rsps.push_back(rs);
                n++;
            end
            if (n > 0)
                expected_rsps[$].last = 1'b1;
        end
    endtask

    // sample handshakes at the rising edge
    logic s_axis_tready_q = 1'b0;
    always @(posedge clk)
        s_axis_tready_q <= s_axis_tready;

    // driver: bursts with random gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready_q) begin
                predict_table_op(pending_reqs.pop_front());
            end
            if (!(s_axis_tvalid && !s_axis_tready_q)) begin
                if (gap_left > 0 || hold_sender || pending_reqs.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {5'd0, pending_reqs[0]};
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end else
                        burst_left--;
                end
            end
        end
    end

    int stall_pat = 0;
    int stall_cnt = 0;
    always @(negedge clk)
    begin
        if (long_stall && stall_cnt < 300) begin
            stall_cnt++;
            m_axis_tready <= 1'b0;
        end else begin
            stall_pat++;
            case ((stall_pat / 200) % 3)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= (stall_pat % 5 < 2);
            endcase
        end
    end

    // monitor
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t exp_rs;
        if (rst_n) begin
            idle_cycles++;
            if (s_axis_tvalid && s_axis_tready)
                idle_cycles = 0;
            if (m_axis_tvalid && m_axis_tready) begin
                idle_cycles = 0;
                got = {m_axis_tlast, m_axis_tdata[202:0]};
                if (expected_rsps.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h", $time, got);
                    errors++;
                end else begin
                    exp_rs = expected_rsps.pop_front();
                    if (got.status !== exp_rs.status || got.vni !== exp_rs.vni ||
                        got.ip !== exp_rs.ip || got.port !== exp_rs.port ||
                        got.packets !== exp_rs.packets ||
                        got.octets !== exp_rs.octets || got.last !== exp_rs.last)
                    begin
                        $display("%0t mismatch: expected %h actual %h",
                                 $time, exp_rs, got);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_vni(int pool);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return vfrt_pkg::VNI_MAX + $urandom_range(1, 100);
            default: return 32'(100 + $urandom_range(0, pool - 1));
        endcase
    endfunction

    function automatic logic [31:0] pick_ip();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return 32'h0A000000 + $urandom_range(0, 7);
    endfunction

    function automatic req_t make_req(logic [2:0] op, logic [31:0] vni,
                                      logic [31:0] eip, logic [15:0] eport,
                                      logic [31:0] sip);
        req_t r;
        r.op = op;
        r.vni = vni;
        r.eip = eip;
        r.eport = eport;
        r.sip = sip;
        r.pport = 16'($urandom());
        r.plen = 16'($urandom());
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    initial
    begin
        req_t r;
        int   op_pick;
        for (int i = 0; i < vfrt_pkg::TABLE_ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_pkts[i] = '0;
            tbl_octs[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty dump, edge fields, every status except full
        pending_reqs.push_back(make_req(vfrt_pkg::OP_DUMP, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_DISTRIB, 5, 0, 0, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_ADD, 32'hFFFFFFFF, 1, 1, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_ADD, vfrt_pkg::VNI_MAX,
                                        32'hFFFFFFFF, 16'hFFFF, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_ADD, vfrt_pkg::VNI_MAX,
                                        32'hFFFFFFFF, 0, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_ADD, vfrt_pkg::VNI_MAX, 0, 0, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_ADD, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_SET_PORT, vfrt_pkg::VNI_MAX, 0,
                                        16'h8000, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_SET_PORT, 7, 7, 1, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_SET_PORT, vfrt_pkg::VNI_MAX + 1,
                                        0, 1, 0));
        r = make_req(vfrt_pkg::OP_DISTRIB, vfrt_pkg::VNI_MAX, 0, 0, 32'hFFFFFFFF);
        r.plen = 16'hFFFF;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(vfrt_pkg::OP_DISTRIB, vfrt_pkg::VNI_MAX, 0, 0,
                                        32'h12345678));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_DISTRIB, 32'h01FFFFFF, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd5, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd7, 32'hFFFFFFFF, 0, 0, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_DUMP, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_DELETE, vfrt_pkg::VNI_MAX, 0, 0, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_DELETE, vfrt_pkg::VNI_MAX, 0, 0, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_DELETE, 32'hFFFFFFFF, 0, 0, 0));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_DUMP, 0, 0, 0, 0));
        wait_drained();

        // fill the table to full under a long receiver stall, then flood and dump it
        for (int i = 0; i < vfrt_pkg::TABLE_ENTRIES + 2; i++)
            pending_reqs.push_back(make_req(vfrt_pkg::OP_ADD, 32'(i % 3), 32'(i),
                                            16'($urandom()), 0));
        long_stall = 1'b1;
        for (int i = 0; i < 6; i++)
            pending_reqs.push_back(make_req(vfrt_pkg::OP_DISTRIB, 32'(i % 3), 0, 0,
                                            32'($urandom_range(0, 3))));
        pending_reqs.push_back(make_req(vfrt_pkg::OP_DUMP, 0, 0, 0, 0));
        hold_sender = 1'b0;
        wait_drained();
        for (int i = 0; i < vfrt_pkg::TABLE_ENTRIES; i++)
            pending_reqs.push_back(make_req(vfrt_pkg::OP_DELETE, 32'(i % 3), 32'(i), 0, 0));
        wait_drained();

        // random traffic over a small vni and ip pool
        for (int n = 0; n < 300; n++)
        begin
            op_pick = $urandom_range(0, 99);
            if (op_pick < 35)
                r = make_req(vfrt_pkg::OP_ADD, pick_vni(4), pick_ip(),
                             ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom()), 0);
            else if (op_pick < 45)
                r = make_req(vfrt_pkg::OP_SET_PORT, pick_vni(4), pick_ip(),
                             16'($urandom()), 0);
            else if (op_pick < 60)
                r = make_req(vfrt_pkg::OP_DELETE, pick_vni(4), pick_ip(), 0, 0);
            else if (op_pick < 88)
                r = make_req(vfrt_pkg::OP_DISTRIB, pick_vni(4), $urandom(),
                             16'($urandom()), pick_ip());
            else if (op_pick < 96)
                r = make_req(vfrt_pkg::OP_DUMP, $urandom(), $urandom(),
                             16'($urandom()), $urandom());
            else
                r = make_req(3'($urandom_range(5, 7)), $urandom(), $urandom(), 0, 0);
            pending_reqs.push_back(r);
            if (n == 150) begin
                // stop queueing requests until everything has drained
                wait_drained();
            end
        end
        wait_drained();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
